// ----- rtl/rdct_pkg.sv -----
package rdct_pkg;

    localparam int DATA_W = 24;

    // Operation codes of a request.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register selects.
    localparam logic [1:0] SEL_CTRL   = 2'd0;
    localparam logic [1:0] SEL_RELOAD = 2'd1;
    localparam logic [1:0] SEL_VALUE  = 2'd2;

    // Bit positions in the control register.
    localparam int CTRL_EN_BIT     = 0;
    localparam int CTRL_IRQEN_BIT  = 1;
    localparam int CTRL_CLKSRC_BIT = 2;
    localparam int CTRL_FLAG_BIT   = 16;

    typedef struct packed {
        logic [1:0]        op;
        logic [1:0]        reg_sel;
        logic [DATA_W-1:0] write_data;
    } t_rdct_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              expired;
        logic [DATA_W-1:0] elapsed;
    } t_rdct_rsp;

endpackage

// ----- rtl/rdct_req_if.sv -----
interface rdct_req_if;
    logic                 valid;
    logic                 ready;
    rdct_pkg::t_rdct_req  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rdct_rsp_if.sv -----
interface rdct_rsp_if;
    logic                 valid;
    logic                 ready;
    rdct_pkg::t_rdct_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/reload_down_counter_timer.sv -----
// Reload down-counter timer with control, reload and current-value registers.
// Each request is a clock tick, a register read or a register write, and each
// request produces exactly one response carrying read data, the irq pulse,
// the expiry flag and the elapsed count (reload minus current value).
// One request is taken every cycle while the response side does not stall; a
// request waits in the input register until the result register takes its
// response. The two stages keep flowing while the response side stalls as
// long as a stage has room.
// The one_shot bit (write enable and data on i_cfg_*) makes an expiry clear
// enable and interrupt enable; write it only while idle.
module reload_down_counter_timer #(
    parameter int COUNT_WIDTH  = 24,
    parameter int PRESCALE_DIV = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    rdct_req_if.sink    i_req,
    rdct_rsp_if.source  o_rsp
);
    import rdct_pkg::*;

    localparam int PRE_W = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;

    logic                   r_one_shot;
    logic                   r_in_valid;
    t_rdct_req              r_in;
    logic                   r_out_valid;
    t_rdct_rsp              r_out;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [COUNT_WIDTH-1:0] r_reload, n_reload;
    logic                   r_run, n_run;
    logic                   r_irqen, n_irqen;
    logic                   r_clksrc, n_clksrc;
    logic                   r_flag, n_flag;
    logic [PRE_W-1:0]       r_pre, n_pre;

    t_rdct_rsp              n_out;
    logic [COUNT_WIDTH-1:0] w_elapsed;
    logic [COUNT_WIDTH-1:0] w_wdata_cnt;
    logic [DATA_W-1:0]      w_reload_o;
    logic [DATA_W-1:0]      w_count_o;
    logic [DATA_W-1:0]      w_elapsed_o;
    logic                   w_adv;
    logic                   w_fire;
    logic                   w_pulse;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_in_valid && w_adv;
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign w_pulse   = (r_pre == PRE_W'(PRESCALE_DIV - 1));
    assign w_elapsed = n_reload - n_count;

    // Fit counter-width values to the fixed 24-bit bus fields.
    generate
        if (COUNT_WIDTH >= DATA_W) begin : g_trunc
            assign w_reload_o  = r_reload[DATA_W-1:0];
            assign w_count_o   = r_count[DATA_W-1:0];
            assign w_elapsed_o = w_elapsed[DATA_W-1:0];
            assign w_wdata_cnt = COUNT_WIDTH'(r_in.write_data);
        end else begin : g_ext
            assign w_reload_o  = {{(DATA_W-COUNT_WIDTH){1'b0}}, r_reload};
            assign w_count_o   = {{(DATA_W-COUNT_WIDTH){1'b0}}, r_count};
            assign w_elapsed_o = {{(DATA_W-COUNT_WIDTH){1'b0}}, w_elapsed};
            assign w_wdata_cnt = r_in.write_data[COUNT_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        n_count        = r_count;
        n_reload       = r_reload;
        n_run          = r_run;
        n_irqen        = r_irqen;
        n_clksrc       = r_clksrc;
        n_flag         = r_flag;
        n_pre          = r_pre;
        n_out          = '0;
        case (r_in.op)
            OP_TICK: begin
                // The prescaler runs on every tick, enabled or not.
                n_pre = w_pulse ? '0 : r_pre + PRE_W'(1);
                if (r_run && (r_clksrc || w_pulse)) begin
                    if (r_count == '0) begin
                        n_count = r_reload;
                    end else begin
                        n_count = r_count - COUNT_WIDTH'(1);
                        if (r_count == COUNT_WIDTH'(1)) begin
                            n_out.expired = 1'b1;
                            n_out.irq     = r_irqen;
                            n_flag        = 1'b1;
                            if (r_one_shot) begin
                                n_run   = 1'b0;
                                n_irqen = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                case (r_in.reg_sel)
                    SEL_CTRL: begin
                        n_out.read_data[CTRL_EN_BIT]     = r_run;
                        n_out.read_data[CTRL_IRQEN_BIT]  = r_irqen;
                        n_out.read_data[CTRL_CLKSRC_BIT] = r_clksrc;
                        n_out.read_data[CTRL_FLAG_BIT]   = r_flag;
                        n_flag = 1'b0;
                    end
                    SEL_RELOAD: n_out.read_data = w_reload_o;
                    SEL_VALUE:  n_out.read_data = w_count_o;
                    default:    n_out.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (r_in.reg_sel)
                    SEL_CTRL: begin
                        n_run    = r_in.write_data[CTRL_EN_BIT];
                        n_irqen  = r_in.write_data[CTRL_IRQEN_BIT];
                        n_clksrc = r_in.write_data[CTRL_CLKSRC_BIT];
                    end
                    SEL_RELOAD: n_reload = w_wdata_cnt;
                    SEL_VALUE: begin
                        n_count = '0;
                        n_flag  = 1'b0;
                    end
                    default: n_flag = r_flag;
                endcase
            end
            default: n_pre = r_pre;
        endcase
        n_out.elapsed = w_elapsed_o;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_shot  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_reload    <= '0;
            r_run       <= 1'b0;
            r_irqen     <= 1'b0;
            r_clksrc    <= 1'b0;
            r_flag      <= 1'b0;
            r_pre       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_one_shot <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_count  <= n_count;
                r_reload <= n_reload;
                r_run    <= n_run;
                r_irqen  <= n_irqen;
                r_clksrc <= n_clksrc;
                r_flag   <= n_flag;
                r_pre    <= n_pre;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

endmodule
